// File: rtl/core/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character codes and helpers shared by the percent decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CASE_BIT   = 8'h20;
    localparam logic [7:0] HEX_TEN    = 8'h0A;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } item_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       out_last;
    } result_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] high_digit;
    } dec_status_t;

    // digit value, letters case-folded; anything else just wraps
    function automatic logic [7:0] hexval(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            hexval = c - CH_ZERO;
        end
        else
        begin
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            begin
                v = c + CASE_BIT;
            end
            hexval = v - CH_LOWER_A + HEX_TEN;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/upd_in_stage.sv
// ----------------------------------------------------------------------------
// upd_in_stage
// Input register: holds one encoded byte request until the decoder takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire upd_pkg::item_t up_data,
    output logic                down_valid,
    input  wire logic           down_ready,
    output upd_pkg::item_t      down_data
);

    logic           valid_reg;
    logic           valid_next;
    upd_pkg::item_t data_reg;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= up_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/upd_decode.sv
// ----------------------------------------------------------------------------
// upd_decode
// Escape tracking and byte mapping; state moves when a request is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_decode (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire upd_pkg::item_t   item,
    output upd_pkg::result_t      result,
    output upd_pkg::dec_status_t  status
);

    upd_pkg::phase_t phase_reg;
    upd_pkg::phase_t phase_next;
    logic [7:0]      high_reg;
    logic [7:0]      high_next;
    logic            is_escape;
    logic [7:0]      plain_byte;
    logic [7:0]      hex_high;
    logic [7:0]      hex_low;

    assign is_escape  = item.in_byte inside {upd_pkg::CH_PERCENT, upd_pkg::CH_NUL};
    assign plain_byte = (item.in_byte == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE
                                                           : item.in_byte;
    assign hex_high   = upd_pkg::hexval(high_reg);
    assign hex_low    = upd_pkg::hexval(item.in_byte);

    always_comb
    begin
        phase_next       = phase_reg;
        high_next        = high_reg;
        result.out_valid = 1'b0;
        result.out_byte  = 8'h00;
        result.out_last  = item.in_last;
        case (phase_reg)
            upd_pkg::PH_HIGH:
            begin
                if (item.in_last)
                begin
                    // escape cut short: drop it, decode this byte as plain text unless it is an opener
                    result.out_valid = !is_escape;
                    result.out_byte  = is_escape ? 8'h00 : plain_byte;
                    phase_next       = upd_pkg::PH_IDLE;
                end
                else
                begin
                    high_next  = item.in_byte;
                    phase_next = upd_pkg::PH_LOW;
                end
            end
            upd_pkg::PH_LOW:
            begin
                result.out_valid = 1'b1;
                result.out_byte  = (hex_high << 4) | hex_low;
                phase_next       = upd_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = upd_pkg::PH_IDLE;
                if (!is_escape)
                begin
                    result.out_valid = 1'b1;
                    result.out_byte  = plain_byte;
                end
                else if (!item.in_last)
                begin
                    phase_next = upd_pkg::PH_HIGH;
                end
            end
        endcase
        if (item.in_last)
        begin
            phase_next = upd_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= upd_pkg::PH_IDLE;
            high_reg  <= 8'h00;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            high_reg  <= high_next;
        end
    end

    assign status.phase      = phase_reg;
    assign status.high_digit = high_reg;

endmodule

`default_nettype wire

// File: rtl/core/upd_out_stage.sv
// ----------------------------------------------------------------------------
// upd_out_stage
// Result register: holds one decoded result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             up_valid,
    output logic                  up_ready,
    input  wire upd_pkg::result_t up_data,
    output logic                  down_valid,
    input  wire logic             down_ready,
    output upd_pkg::result_t      down_data
);

    logic             valid_reg;
    logic             valid_next;
    upd_pkg::result_t data_reg;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= up_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/uri_percent_decoder_top.sv
// ----------------------------------------------------------------------------
// uri_percent_decoder_top
// Streaming percent decoder for URL-encoded text, one byte per request.
//
// The item channel (item_valid / item_ready / item) carries one encoded byte
// and its end-of-text flag per request. The result channel (result_valid /
// result_ready / result) returns exactly one result per request, in order:
// a decoded byte with its own out_valid flag, or out_valid low when the byte
// was swallowed by an escape.
// A taken request is held in the input register, decoded from it, and lands
// in the result register, where the receiver can take it. Throughput is one
// request per cycle while the receiver does not stall, set by the single
// decode pass between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; item_ready drops only when both are full.
// Reset clears both registers' valid flags and returns to outside an escape.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_percent_decoder_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire upd_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output upd_pkg::result_t      result
);

    logic                 held_valid;
    logic                 held_ready;
    upd_pkg::item_t       held_item;
    upd_pkg::result_t     dec_result;
    upd_pkg::dec_status_t dec_status;
    logic                 advance;

    upd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (item_valid),
        .up_ready   (item_ready),
        .up_data    (item),
        .down_valid (held_valid),
        .down_ready (held_ready),
        .down_data  (held_item)
    );

    assign advance = held_valid && held_ready;

    upd_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (held_item),
        .result (dec_result),
        .status (dec_status)
    );

    upd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (held_valid),
        .up_ready   (held_ready),
        .up_data    (dec_result),
        .down_valid (result_valid),
        .down_ready (result_ready),
        .down_data  (result)
    );

    // an empty result slot never carries a stray byte
    a_idle_byte_zero : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.out_valid |-> result.out_byte == 8'h00)
        else $error("result without a byte has nonzero out_byte");

    // end of text always closes any open escape
    a_last_closes : assert property (@(posedge clk) disable iff (!rst_n)
        advance && held_item.in_last |=> dec_status.phase == upd_pkg::PH_IDLE)
        else $error("escape still open after last byte");

    // the low digit of an escape always yields a decoded byte
    a_low_digit_out : assert property (@(posedge clk) disable iff (!rst_n)
        advance && dec_status.phase == upd_pkg::PH_LOW
        |=> result_valid && result.out_valid)
        else $error("low escape digit gave no decoded byte");

    // backpressure reaches the sender only when both registers are full
    a_ready_drop : assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> held_valid && result_valid && !result_ready)
        else $error("item_ready low with room in the pipeline");

    // the held high digit moves only when an escape takes its first digit
    a_high_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && dec_status.phase == upd_pkg::PH_HIGH)
        |=> $stable(dec_status.high_digit))
        else $error("high digit changed outside an escape");

endmodule

`default_nettype wire

// File: verif/uri_percent_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// uri_percent_decoder_top_tb
// Self-checking bench for the streaming percent decoder. A short table of
// directed requests covers plain bytes, '+', both escape openers, truncated
// escapes and the byte extremes. Random texts follow, mostly plain bytes,
// '+' and escapes, some pure noise. Every result is checked against the
// directed table or a local decoder model, under random idling on both
// channels, long receiver stalls and pauses until all results have drained.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_percent_decoder_top_tb;

    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD    = 40;

    typedef struct {
        upd_pkg::item_t   req;
        bit               typed;
        upd_pkg::result_t want;
    } dir_row_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    upd_pkg::item_t   item         = '0;
    logic             result_ready = 1'b0;
    wire              item_ready;
    wire              result_valid;
    upd_pkg::result_t result;

    // decoder model state
    upd_pkg::phase_t dec_phase = upd_pkg::PH_IDLE;
    logic [7:0]      held_high = 8'h00;

    upd_pkg::result_t decoded_q[$];
    upd_pkg::item_t   text_q[$];
    dir_row_t         dir_rows[$];

    int  errors      = 0;
    int  cycle_count = 0;
    int  hold_cycles = 0;
    bit  steady_mode = 1'b0;

    uri_percent_decoder_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("uri_percent_decoder_top_tb failed");
            $finish;
        end
    end

    function automatic logic [7:0] digit_of(input logic [7:0] c);
        logic [7:0] folded;
        if (c >= upd_pkg::CH_ZERO && c <= upd_pkg::CH_NINE)
        begin
            digit_of = c - upd_pkg::CH_ZERO;
        end
        else
        begin
            folded = (c >= upd_pkg::CH_UPPER_A && c <= upd_pkg::CH_UPPER_Z)
                     ? (c | upd_pkg::CASE_BIT) : c;
            digit_of = folded - upd_pkg::CH_LOWER_A + upd_pkg::HEX_TEN;
        end
    endfunction

    function automatic bit opens_escape(input logic [7:0] c);
        opens_escape = (c == upd_pkg::CH_PERCENT) || (c == upd_pkg::CH_NUL);
    endfunction

    function automatic logic [7:0] plain_of(input logic [7:0] c);
        plain_of = (c == upd_pkg::CH_PLUS) ? upd_pkg::CH_SPACE : c;
    endfunction

    task automatic decode_step(input upd_pkg::item_t r, output upd_pkg::result_t res);
        res = '0;
        res.out_last = r.in_last;
        case (dec_phase)
            upd_pkg::PH_HIGH:
            begin
                if (r.in_last)
                begin
                    // escape cut short: the lone byte decodes as plain text unless it is an opener
                    if (!opens_escape(r.in_byte))
                    begin
                        res.out_valid = 1'b1;
                        res.out_byte  = plain_of(r.in_byte);
                    end
                    dec_phase = upd_pkg::PH_IDLE;
                end
                else
                begin
                    held_high = r.in_byte;
                    dec_phase = upd_pkg::PH_LOW;
                end
            end
            upd_pkg::PH_LOW:
            begin
                res.out_valid = 1'b1;
                res.out_byte  = (digit_of(held_high) << 4) | digit_of(r.in_byte);
                dec_phase     = upd_pkg::PH_IDLE;
            end
            default:
            begin
                dec_phase = upd_pkg::PH_IDLE;
                if (!opens_escape(r.in_byte))
                begin
                    res.out_valid = 1'b1;
                    res.out_byte  = plain_of(r.in_byte);
                end
                else if (!r.in_last)
                begin
                    dec_phase = upd_pkg::PH_HIGH;
                end
            end
        endcase
        if (r.in_last)
        begin
            dec_phase = upd_pkg::PH_IDLE;
        end
    endtask

    function automatic dir_row_t dir_row(input logic [7:0] b, input bit last, input bit typed,
                                         input bit v, input logic [7:0] ob, input bit ol);
        dir_row_t d;
        d.req   = '{in_byte: b, in_last: last};
        d.typed = typed;
        d.want  = '{out_valid: v, out_byte: ob, out_last: ol};
        return d;
    endfunction

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
        begin
            return upd_pkg::CH_ZERO + 8'(v);
        end
        else if (v < 16)
        begin
            return upd_pkg::CH_LOWER_A + 8'(v - 10);
        end
        return upd_pkg::CH_UPPER_A + 8'(v - 16);
    endfunction

    function automatic logic [7:0] rand_opener();
        return ($urandom_range(0, 3) == 0) ? upd_pkg::CH_NUL : upd_pkg::CH_PERCENT;
    endfunction

    task automatic push_text_byte(input logic [7:0] b);
        text_q.push_back('{in_byte: b, in_last: 1'b0});
    endtask

    task automatic build_text(input bit noisy);
        int             len;
        upd_pkg::item_t tail;
        text_q.delete();
        len = $urandom_range(1, 12);
        while (text_q.size() < len)
        begin
            if (noisy)
            begin
                case ($urandom_range(0, 3))
                    0:       push_text_byte(upd_pkg::CH_PERCENT);
                    1:       push_text_byte(upd_pkg::CH_NUL);
                    default: push_text_byte(8'($urandom_range(0, 255)));
                endcase
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        push_text_byte(upd_pkg::CH_PLUS);
                    end
                    1, 2, 3:
                    begin
                        push_text_byte(rand_opener());
                        push_text_byte(rand_hex_char());
                        push_text_byte(rand_hex_char());
                    end
                    4:
                    begin
                        // opener and one digit, may be cut off by the end of text
                        push_text_byte(rand_opener());
                        push_text_byte(rand_hex_char());
                    end
                    5:
                    begin
                        push_text_byte(rand_opener());
                    end
                    default:
                    begin
                        push_text_byte(8'($urandom_range(8'h21, 8'h7e)));
                    end
                endcase
            end
        end
        tail = text_q.pop_back();
        tail.in_last = 1'b1;
        text_q.push_back(tail);
    endtask

    task automatic send_byte(input upd_pkg::item_t r, input bit typed,
                             input upd_pkg::result_t want);
        int               gap;
        upd_pkg::result_t predicted;
        gap = steady_mode ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= r;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        decode_step(r, predicted);
        decoded_q.push_back(typed ? want : predicted);
    endtask

    task automatic wait_results_drained();
        item_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (decoded_q.size() != 0);
    endtask

    task automatic note_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        errors++;
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
    endtask

    // result side
    initial
    begin
        int               stall;
        upd_pkg::result_t want;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                stall = steady_mode ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
            if (decoded_q.size() == 0)
            begin
                note_mismatch("unexpected result", 8'h00, result.out_byte);
            end
            else
            begin
                want = decoded_q.pop_front();
                if (result.out_valid !== want.out_valid)
                begin
                    note_mismatch("out_valid", 8'(want.out_valid), 8'(result.out_valid));
                end
                if (result.out_byte !== want.out_byte)
                begin
                    note_mismatch("out_byte", want.out_byte, result.out_byte);
                end
                if (result.out_last !== want.out_last)
                begin
                    note_mismatch("out_last", 8'(want.out_last), 8'(result.out_last));
                end
            end
        end
    end

    // request side
    initial
    begin
        int sent;
        int n_texts;
        sent    = 0;
        n_texts = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        dir_rows.push_back(dir_row(8'h41, 1'b0, 1'b1, 1'b1, 8'h41, 1'b0));
        dir_rows.push_back(dir_row(upd_pkg::CH_PLUS, 1'b0, 1'b1, 1'b1,
                                   upd_pkg::CH_SPACE, 1'b0));
        dir_rows.push_back(dir_row(8'hff, 1'b0, 1'b1, 1'b1, 8'hff, 1'b0));
        dir_rows.push_back(dir_row(8'h01, 1'b1, 1'b1, 1'b1, 8'h01, 1'b1));
        dir_rows.push_back(dir_row(upd_pkg::CH_PERCENT, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(8'h34, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(8'h31, 1'b0, 1'b1, 1'b1, 8'h41, 1'b0));
        dir_rows.push_back(dir_row(upd_pkg::CH_PERCENT, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(8'h66, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(8'h46, 1'b1, 1'b1, 1'b1, 8'hff, 1'b1));
        // zero byte opens an escape too
        dir_rows.push_back(dir_row(upd_pkg::CH_NUL, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(8'h32, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(8'h62, 1'b0, 1'b1, 1'b1, upd_pkg::CH_PLUS, 1'b0));
        // opener as the last byte is dropped
        dir_rows.push_back(dir_row(upd_pkg::CH_PERCENT, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1));
        // a last byte after the opener decodes as plain text, an opener is dropped
        dir_rows.push_back(dir_row(upd_pkg::CH_PERCENT, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(upd_pkg::CH_PLUS, 1'b1, 1'b1, 1'b1,
                                   upd_pkg::CH_SPACE, 1'b1));
        dir_rows.push_back(dir_row(upd_pkg::CH_PERCENT, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(upd_pkg::CH_PERCENT, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1));
        dir_rows.push_back(dir_row(upd_pkg::CH_NUL, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(upd_pkg::CH_NUL, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1));
        dir_rows.push_back(dir_row(upd_pkg::CH_PERCENT, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(8'h7a, 1'b1, 1'b1, 1'b1, 8'h7a, 1'b1));
        // opener inside an escape is a digit, non-hex low digit wraps
        dir_rows.push_back(dir_row(upd_pkg::CH_PERCENT, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(upd_pkg::CH_PERCENT, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(8'h67, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(upd_pkg::CH_NUL, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(8'hff, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
        dir_rows.push_back(dir_row(8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0));

        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        end

        while (sent < RANDOM_ITEMS)
        begin
            n_texts++;
            steady_mode = (n_texts % 15) >= 12;
            if (n_texts == 10 || n_texts == 45)
            begin
                // receiver stalls long while requests keep coming
                hold_cycles = LONG_HOLD;
            end
            if (n_texts % 25 == 0)
            begin
                wait_results_drained();
            end
            build_text($urandom_range(0, 4) == 0);
            foreach (text_q[k])
            begin
                send_byte(text_q[k], 1'b0, '0);
                sent++;
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("uri_percent_decoder_top_tb passed");
        end
        else
        begin
            $display("uri_percent_decoder_top_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/upd_pkg.sv
rtl/core/upd_in_stage.sv
rtl/core/upd_decode.sv
rtl/core/upd_out_stage.sv
rtl/core/uri_percent_decoder_top.sv
verif/uri_percent_decoder_top_tb.sv
